/* src/scoped_symbol_stack_core_defines.svh */
// Assertion macros used by the core RTL file.
`ifndef SCOPED_SYMBOL_STACK_CORE_DEFINES_SVH
`define SCOPED_SYMBOL_STACK_CORE_DEFINES_SVH

// Same-cycle implication, checked at each rising clock edge outside reset.
`define SCS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define SCS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* src/scs_pkg.sv */
package scs_pkg;

   localparam int DEFAULT_STACK_DEPTH = 256;
   localparam int MARK_W              = 9;
   localparam int KEY_W               = 32;
   localparam int HANDLE_W            = 32;

   typedef enum logic [1:0] {
      MODE_PUSH   = 2'd0,
      MODE_LOOKUP = 2'd1,
      MODE_OPEN   = 2'd2,
      MODE_CLOSE  = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      STAT_PUSHED    = 3'd0,
      STAT_IGNORED   = 3'd1,
      STAT_REDEFINED = 3'd2,
      STAT_OVERFLOW  = 3'd3,
      STAT_FOUND     = 3'd4,
      STAT_NOTFOUND  = 3'd5,
      STAT_OPENED    = 3'd6,
      STAT_CLOSED    = 3'd7
   } status_type;

   typedef struct packed {
      mode_type              mode;
      logic [KEY_W-1:0]      symbol_key;
      logic [HANDLE_W-1:0]   object_handle;
      logic [MARK_W-1:0]     saved_mark;
      logic                  skip_local;
   } req_type;

   typedef struct packed {
      status_type            status;
      logic [HANDLE_W-1:0]   result_handle;
      logic [MARK_W-1:0]     scope_mark;
   } rsp_type;

   // One stack slot as held in the entry RAM.
   typedef struct packed {
      logic [KEY_W-1:0]      key;
      logic [HANDLE_W-1:0]   handle;
   } entry_type;

endpackage

/* src/scoped_symbol_stack_core.sv */
// Scoped symbol stack. An item is taken on a clock edge with start high and
// busy low; its single result appears on rsp_item for exactly one cycle with
// rsp_strobe high, and must be captured then since the receiver cannot stall.
// Open scope, close scope, push of key zero and lookups that skip the stack
// search (skip_local set or key zero) answer in the cycle after acceptance and
// leave busy low, so one such item can be taken every cycle. Push and lookup
// scan the entry RAM one slot per cycle from the newest entry: a push scans
// the current scope, a lookup every open scope. Such an item keeps busy high
// while it compares slots, newest first, up to and including a match, or
// every slot of the range on a miss (at most STACK_DEPTH); the read data of
// the entry RAM is registered ahead of each compare. The result is on the
// ports in the first cycle with busy low again. The single RAM read port sets
// the scan rate. No clearing pass is needed after reset.
module scoped_symbol_stack_core #(
   parameter int STACK_DEPTH = scs_pkg::DEFAULT_STACK_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  scs_pkg::req_type req_item,
   output logic             rsp_strobe,
   output scs_pkg::rsp_type rsp_item
);

`include "scoped_symbol_stack_core_defines.svh"

   localparam int PTR_W  = $clog2(STACK_DEPTH + 1);
   localparam int IDX_W  = $clog2(STACK_DEPTH);
   localparam int CMP_W  = (PTR_W > scs_pkg::MARK_W) ? PTR_W : scs_pkg::MARK_W;
   localparam logic [PTR_W-1:0] DEPTH_PTR = PTR_W'(STACK_DEPTH);
   localparam logic [CMP_W-1:0] DEPTH_CMP = CMP_W'(STACK_DEPTH);

   typedef enum logic [1:0] {
      FSM_IDLE = 2'b01,
      FSM_SCAN = 2'b10
   } fsm_type;

   fsm_type                        state_ff, state_in;
   logic [PTR_W-1:0]               bottom_ff, bottom_in;
   logic [PTR_W-1:0]               top_ff, top_in;
   logic [PTR_W-1:0]               ptr_ff, ptr_in;
   logic [PTR_W-1:0]               hi_ff, hi_in;
   logic                           rd_vld_ff, rd_vld_in;
   logic                           is_push_ff, is_push_in;
   logic [scs_pkg::KEY_W-1:0]      key_ff, key_in;
   logic [scs_pkg::HANDLE_W-1:0]   obj_ff, obj_in;
   logic                           strobe_ff, strobe_in;
   scs_pkg::rsp_type               rsp_ff, rsp_in;

   logic                           accept;
   logic                           issue;
   logic                           hit;
   logic                           wr_en;
   logic [IDX_W-1:0]               wr_addr;
   logic [CMP_W-1:0]               mark_cmp;
   logic [PTR_W-1:0]               mark_sat;
   logic [PTR_W-1:0]               bottom_dec;
   scs_pkg::entry_type             wr_data;
   scs_pkg::entry_type             rd_data;

   assign accept     = start && (state_ff == FSM_IDLE);
   assign issue      = (state_ff == FSM_SCAN) && (ptr_ff < hi_ff);
   assign hit        = rd_vld_ff && (rd_data.key == key_ff);
   assign bottom_dec = bottom_ff - PTR_W'(1);
   assign wr_addr    = bottom_dec[IDX_W-1:0];
   assign wr_data    = '{key: key_ff, handle: obj_ff};

   // Close-scope mark: saturate to the depth, then raise to the new bottom.
   always_comb begin
      mark_cmp = CMP_W'(req_item.saved_mark);
      if (mark_cmp > DEPTH_CMP) begin
         mark_sat = DEPTH_PTR;
      end else begin
         mark_sat = mark_cmp[PTR_W-1:0];
      end
      if (mark_sat < top_ff) begin
         mark_sat = top_ff;
      end
   end

   // Control and datapath next state.
   always_comb begin
      state_in   = state_ff;
      bottom_in  = bottom_ff;
      top_in     = top_ff;
      ptr_in     = ptr_ff;
      hi_in      = hi_ff;
      rd_vld_in  = 1'b0;
      is_push_in = is_push_ff;
      key_in     = key_ff;
      obj_in     = obj_ff;
      strobe_in  = 1'b0;
      rsp_in     = rsp_ff;
      wr_en      = 1'b0;

      case (state_ff)
         FSM_IDLE: begin
            if (accept) begin
               key_in = req_item.symbol_key;
               obj_in = req_item.object_handle;
               rsp_in = '{status: scs_pkg::STAT_CLOSED, result_handle: '0,
                          scope_mark: '0};
               case (req_item.mode)
                  scs_pkg::MODE_PUSH: begin
                     if (req_item.symbol_key == '0) begin
                        strobe_in     = 1'b1;
                        rsp_in.status = scs_pkg::STAT_IGNORED;
                     end else begin
                        state_in   = FSM_SCAN;
                        is_push_in = 1'b1;
                        ptr_in     = bottom_ff;
                        hi_in      = top_ff;
                     end
                  end
                  scs_pkg::MODE_LOOKUP: begin
                     if (req_item.skip_local || (req_item.symbol_key == '0)) begin
                        strobe_in     = 1'b1;
                        rsp_in.status = scs_pkg::STAT_NOTFOUND;
                     end else begin
                        state_in   = FSM_SCAN;
                        is_push_in = 1'b0;
                        ptr_in     = bottom_ff;
                        hi_in      = DEPTH_PTR;
                     end
                  end
                  scs_pkg::MODE_OPEN: begin
                     strobe_in         = 1'b1;
                     rsp_in.status     = scs_pkg::STAT_OPENED;
                     rsp_in.scope_mark = scs_pkg::MARK_W'(top_ff);
                     top_in            = bottom_ff;
                  end
                  default: begin
                     strobe_in     = 1'b1;
                     rsp_in.status = scs_pkg::STAT_CLOSED;
                     bottom_in     = top_ff;
                     top_in        = mark_sat;
                  end
               endcase
            end
         end
         FSM_SCAN: begin
            if (hit) begin
               // First match wins: newest entry first.
               state_in             = FSM_IDLE;
               strobe_in            = 1'b1;
               rsp_in.result_handle = rd_data.handle;
               rsp_in.status        = is_push_ff ? scs_pkg::STAT_REDEFINED
                                                 : scs_pkg::STAT_FOUND;
            end else if (!issue) begin
               // Range exhausted and last compare missed.
               state_in  = FSM_IDLE;
               strobe_in = 1'b1;
               if (!is_push_ff) begin
                  rsp_in.status = scs_pkg::STAT_NOTFOUND;
               end else if (bottom_ff == '0) begin
                  rsp_in.status = scs_pkg::STAT_OVERFLOW;
               end else begin
                  rsp_in.status = scs_pkg::STAT_PUSHED;
                  bottom_in     = bottom_dec;
                  wr_en         = 1'b1;
               end
            end else begin
               ptr_in    = ptr_ff + PTR_W'(1);
               rd_vld_in = 1'b1;
            end
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= FSM_IDLE;
         bottom_ff <= DEPTH_PTR;
         top_ff    <= DEPTH_PTR;
         rd_vld_ff <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         bottom_ff <= bottom_in;
         top_ff    <= top_in;
         rd_vld_ff <= rd_vld_in;
         strobe_ff <= strobe_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      ptr_ff     <= ptr_in;
      hi_ff      <= hi_in;
      is_push_ff <= is_push_in;
      key_ff     <= key_in;
      obj_ff     <= obj_in;
      rsp_ff     <= rsp_in;
   end

   scs_entry_ram #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (issue),
      .rd_addr (ptr_ff[IDX_W-1:0]),
      .rd_data (rd_data)
   );

   assign busy       = (state_ff != FSM_IDLE);
   assign rsp_strobe = strobe_ff;
   assign rsp_item   = rsp_ff;

   // Checks.
   `SCS_ASSERT_NOW(a_bottom_le_top, clock, reset, 1'b1, bottom_ff <= top_ff,
      "stack bottom above scope top")
   `SCS_ASSERT_NOW(a_top_in_range, clock, reset, 1'b1, top_ff <= DEPTH_PTR,
      "scope top beyond stack depth")
   `SCS_ASSERT_NOW(a_rd_vld_scan, clock, reset, rd_vld_ff, state_ff == FSM_SCAN,
      "read data pending outside a scan")
   `SCS_ASSERT_NOW(a_no_strobe_scan, clock, reset, state_ff == FSM_SCAN, !strobe_ff,
      "result strobe during a scan")
   `SCS_ASSERT_NEXT(a_push_commit, clock, reset, wr_en,
      (bottom_ff == $past(bottom_dec)) && rsp_item.status == scs_pkg::STAT_PUSHED,
      "push commit did not move the stack bottom")

endmodule

/* src/scs_entry_ram.sv */
// Single-port-write, single-port-read entry store with registered read data.
module scs_entry_ram #(
   parameter int STACK_DEPTH = scs_pkg::DEFAULT_STACK_DEPTH
) (
   input  logic                           clock,
   input  logic                           wr_en,
   input  logic [$clog2(STACK_DEPTH)-1:0] wr_addr,
   input  scs_pkg::entry_type             wr_data,
   input  logic                           rd_en,
   input  logic [$clog2(STACK_DEPTH)-1:0] rd_addr,
   output scs_pkg::entry_type             rd_data
);

   scs_pkg::entry_type mem [STACK_DEPTH];
   scs_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* verif/scoped_symbol_stack_core_test.sv */
`timescale 1ns / 100ps

module scoped_symbol_stack_core_test;
   import scs_pkg::*;

   localparam int DEPTH        = DEFAULT_STACK_DEPTH;
   localparam int RANDOM_ITEMS = 850;
   localparam int CYCLE_LIMIT  = 1_500_000;
   localparam int DRAIN_CYCLES = DEPTH + 8;
   localparam int FILL_KEY     = 32'hC000_0000;

   typedef struct {
      req_type item;
      bit      typed;
      rsp_type result;
   } stim_row_type;

   logic    clock    = 1'b0;
   logic    reset    = 1'b1;
   logic    start    = 1'b0;
   req_type req_item = '0;
   logic    busy;
   logic    rsp_strobe;
   rsp_type rsp_item;

   // Shadow copy of the stack and its scope pointers
   logic [KEY_W-1:0]    shadow_keys    [DEPTH];
   logic [HANDLE_W-1:0] shadow_handles [DEPTH];
   logic [MARK_W-1:0]   shadow_bottom  = MARK_W'(DEPTH);
   logic [MARK_W-1:0]   shadow_top     = MARK_W'(DEPTH);

   rsp_type           pending_results [$];
   logic [MARK_W-1:0] open_marks [$];
   stim_row_type      directed_rows [$];
   rsp_type           last_result;
   int                mismatches  = 0;
   int                cycle_count = 0;
   int                items_sent  = 0;
   int                quiet_left  = 0;

   scoped_symbol_stack_core #(
      .STACK_DEPTH(DEPTH)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Search slots lo .. hi-1, newest first, for key
   function automatic bit find_symbol(input int lo, input int hi,
                                      input logic [KEY_W-1:0] key,
                                      output logic [HANDLE_W-1:0] handle);
      handle = '0;
      for (int i = lo; i < hi && i < DEPTH; i++) begin
         if (shadow_keys[i] == key) begin
            handle = shadow_handles[i];
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   // Advance the shadow stack by one item and return the result it gives
   function automatic rsp_type predict_symbol_result(input req_type it);
      rsp_type             r;
      logic [HANDLE_W-1:0] h;
      int                  mark;
      r = '0;
      case (it.mode)
         MODE_PUSH: begin
            if (it.symbol_key == '0) begin
               r.status = STAT_IGNORED;
            end else if (find_symbol(int'(shadow_bottom), int'(shadow_top),
                                     it.symbol_key, h)) begin
               r.status        = STAT_REDEFINED;
               r.result_handle = h;
            end else if (shadow_bottom == '0) begin
               r.status = STAT_OVERFLOW;
            end else begin
               shadow_bottom                 = shadow_bottom - 1'b1;
               shadow_keys[shadow_bottom]    = it.symbol_key;
               shadow_handles[shadow_bottom] = it.object_handle;
               r.status                      = STAT_PUSHED;
            end
         end
         MODE_LOOKUP: begin
            if (!it.skip_local && it.symbol_key != '0 &&
                find_symbol(int'(shadow_bottom), DEPTH, it.symbol_key, h)) begin
               r.status        = STAT_FOUND;
               r.result_handle = h;
            end else begin
               r.status = STAT_NOTFOUND;
            end
         end
         MODE_OPEN: begin
            r.scope_mark = shadow_top;
            shadow_top   = shadow_bottom;
            r.status     = STAT_OPENED;
         end
         default: begin
            // close: drop the scope, clamp the restored mark into range
            shadow_bottom = shadow_top;
            mark          = int'(it.saved_mark);
            if (mark > DEPTH) mark = DEPTH;
            if (mark < int'(shadow_bottom)) mark = int'(shadow_bottom);
            shadow_top = MARK_W'(mark);
            r.status   = STAT_CLOSED;
         end
      endcase
      return r;
   endfunction

   function automatic stim_row_type make_row(input mode_type m,
                                             input logic [KEY_W-1:0] key,
                                             input logic [HANDLE_W-1:0] handle,
                                             input logic [MARK_W-1:0] mark,
                                             input logic skip, input bit typed,
                                             input status_type st,
                                             input logic [HANDLE_W-1:0] rhandle,
                                             input logic [MARK_W-1:0] smark);
      stim_row_type row;
      row.item.mode            = m;
      row.item.symbol_key      = key;
      row.item.object_handle   = handle;
      row.item.saved_mark      = mark;
      row.item.skip_local      = skip;
      row.typed                = typed;
      row.result.status        = st;
      row.result.result_handle = rhandle;
      row.result.scope_mark    = smark;
      return row;
   endfunction

   // Mostly a small pool of keys so pushes collide and lookups hit
   function automatic logic [KEY_W-1:0] pick_symbol();
      case ($urandom_range(0, 19))
         0:             return '0;
         1:             return '1;
         2, 3, 4, 5, 6: return $urandom();
         default:       return KEY_W'($urandom_range(1, 8));
      endcase
   endfunction

   // Present one item, wait for it to be taken, then idle a random while
   task automatic send_item(input req_type it, input bit typed,
                            input rsp_type typed_result);
      rsp_type predicted;
      int      gap;
      if (!start) start <= 1'b1;
      req_item <= it;
      @(posedge clock);
      while (busy) @(posedge clock);
      predicted = predict_symbol_result(it);
      pending_results.push_back(typed ? typed_result : predicted);
      last_result = predicted;
      items_sent++;
      if (quiet_left > 0) begin
         quiet_left--;
         gap = 0;
      end else if ($urandom_range(0, 19) == 0) begin
         quiet_left = $urandom_range(5, 30);
         gap        = 0;
      end else begin
         gap = $urandom_range(0, 15);
      end
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_random_item();
      req_type it;
      int      pick;
      it.symbol_key    = pick_symbol();
      it.object_handle = $urandom();
      it.saved_mark    = MARK_W'($urandom_range(0, 511));
      it.skip_local    = 1'($urandom_range(0, 1));
      pick             = $urandom_range(0, 99);
      if (pick < 45) begin
         it.mode = MODE_PUSH;
      end else if (pick < 70) begin
         it.mode       = MODE_LOOKUP;
         it.skip_local = ($urandom_range(0, 6) == 0);
      end else if (pick < 85) begin
         it.mode = MODE_OPEN;
      end else begin
         it.mode = MODE_CLOSE;
         // usually restore the mark of the matching open, sometimes junk
         if ($urandom_range(0, 4) != 0)
            it.saved_mark = open_marks.size() > 0 ? open_marks.pop_back() : MARK_W'(DEPTH);
      end
      send_item(it, 1'b0, '0);
      if (it.mode == MODE_OPEN) open_marks.push_back(last_result.scope_mark);
   endtask

   // Push unique keys in short scopes until three pushes overflow, then look up two and unwind
   task automatic fill_stack();
      req_type it;
      int      base_depth;
      int      in_scope;
      int      pushed;
      int      overflows;
      base_depth = open_marks.size();
      in_scope   = 16;
      pushed     = 0;
      overflows  = 0;
      it         = '0;
      while (overflows < 3) begin
         it.object_handle = $urandom();
         if (in_scope == 16) begin
            it.mode = MODE_OPEN;
            send_item(it, 1'b0, '0);
            open_marks.push_back(last_result.scope_mark);
            in_scope = 0;
         end else begin
            it.mode       = MODE_PUSH;
            it.symbol_key = FILL_KEY + pushed;
            send_item(it, 1'b0, '0);
            if (last_result.status == STAT_OVERFLOW) overflows++;
            pushed++;
            in_scope++;
         end
      end
      // deepest and a recent entry, both through the full stack
      it.mode       = MODE_LOOKUP;
      it.skip_local = 1'b0;
      it.symbol_key = FILL_KEY;
      send_item(it, 1'b0, '0);
      it.symbol_key = FILL_KEY + pushed - 6;
      send_item(it, 1'b0, '0);
      it.mode = MODE_CLOSE;
      while (open_marks.size() > base_depth) begin
         it.saved_mark = open_marks.pop_back();
         send_item(it, 1'b0, '0);
      end
   endtask

   // Result checker: every strobe must match the oldest pending result
   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result: expected none, got status %0d handle %h mark %0d",
                     $time, rsp_item.status, rsp_item.result_handle, rsp_item.scope_mark);
            mismatches++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_item.status !== want.status) begin
               $display("%0t: status mismatch: expected %0d, got %0d",
                        $time, want.status, rsp_item.status);
               mismatches++;
            end
            if (rsp_item.result_handle !== want.result_handle) begin
               $display("%0t: result_handle mismatch: expected %h, got %h",
                        $time, want.result_handle, rsp_item.result_handle);
               mismatches++;
            end
            if (rsp_item.scope_mark !== want.scope_mark) begin
               $display("%0t: scope_mark mismatch: expected %0d, got %0d",
                        $time, want.scope_mark, rsp_item.scope_mark);
               mismatches++;
            end
         end
      end
   end

   // Watchdog
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Some tests failed");
      $finish;
   end

   initial begin
      int fill_at;
      int stop_at;
      bit filled;

      for (int i = 0; i < DEPTH; i++) begin
         shadow_keys[i]    = '0;
         shadow_handles[i] = '0;
      end

      // directed table: empty stack first, then two nested scopes
      directed_rows.push_back(make_row(MODE_LOOKUP, 32'd5, '0, '0, 1'b0,
                                       1'b1, STAT_NOTFOUND, '0, '0));
      directed_rows.push_back(make_row(MODE_PUSH, '0, '1, '0, 1'b0,
                                       1'b1, STAT_IGNORED, '0, '0));
      directed_rows.push_back(make_row(MODE_PUSH, '1, '1, '0, 1'b0,
                                       1'b1, STAT_PUSHED, '0, '0));
      directed_rows.push_back(make_row(MODE_PUSH, 32'd1, '0, '1, 1'b1,
                                       1'b1, STAT_PUSHED, '0, '0));
      directed_rows.push_back(make_row(MODE_PUSH, '1, 32'd123, '0, 1'b0,
                                       1'b1, STAT_REDEFINED, '1, '0));
      directed_rows.push_back(make_row(MODE_LOOKUP, '1, '0, '0, 1'b0,
                                       1'b1, STAT_FOUND, '1, '0));
      directed_rows.push_back(make_row(MODE_LOOKUP, '1, '0, '0, 1'b1,
                                       1'b1, STAT_NOTFOUND, '0, '0));
      directed_rows.push_back(make_row(MODE_LOOKUP, '0, '0, '0, 1'b0,
                                       1'b1, STAT_NOTFOUND, '0, '0));
      directed_rows.push_back(make_row(MODE_OPEN, '0, '0, '0, 1'b0,
                                       1'b1, STAT_OPENED, '0, MARK_W'(DEPTH)));
      directed_rows.push_back(make_row(MODE_PUSH, 32'd1, 32'd77, '0, 1'b0,
                                       1'b0, STAT_PUSHED, '0, '0));
      directed_rows.push_back(make_row(MODE_LOOKUP, 32'd1, '0, '0, 1'b0,
                                       1'b0, STAT_PUSHED, '0, '0));
      directed_rows.push_back(make_row(MODE_OPEN, '0, '0, '0, 1'b0,
                                       1'b0, STAT_PUSHED, '0, '0));
      directed_rows.push_back(make_row(MODE_LOOKUP, '1, '0, '0, 1'b0,
                                       1'b0, STAT_PUSHED, '0, '0));
      directed_rows.push_back(make_row(MODE_PUSH, '1, 32'hAAAA_5555, '0, 1'b0,
                                       1'b0, STAT_PUSHED, '0, '0));
      directed_rows.push_back(make_row(MODE_LOOKUP, '1, '0, '0, 1'b0,
                                       1'b0, STAT_PUSHED, '0, '0));
      directed_rows.push_back(make_row(MODE_CLOSE, '0, '0, 9'd254, 1'b0,
                                       1'b1, STAT_CLOSED, '0, '0));
      directed_rows.push_back(make_row(MODE_LOOKUP, '1, '0, '0, 1'b0,
                                       1'b0, STAT_PUSHED, '0, '0));
      // mark below the stack bottom is raised, above the depth is saturated
      directed_rows.push_back(make_row(MODE_CLOSE, '0, '0, 9'd0, 1'b0,
                                       1'b1, STAT_CLOSED, '0, '0));
      directed_rows.push_back(make_row(MODE_CLOSE, '0, '0, 9'd511, 1'b1,
                                       1'b1, STAT_CLOSED, '0, '0));
      directed_rows.push_back(make_row(MODE_LOOKUP, 32'd1, '0, '0, 1'b0,
                                       1'b0, STAT_PUSHED, '0, '0));
      directed_rows.push_back(make_row(MODE_CLOSE, '0, '0, 9'd300, 1'b0,
                                       1'b1, STAT_CLOSED, '0, '0));
      directed_rows.push_back(make_row(MODE_LOOKUP, 32'd1, '0, '0, 1'b0,
                                       1'b1, STAT_NOTFOUND, '0, '0));
      directed_rows.push_back(make_row(MODE_OPEN, '1, '1, '1, 1'b1,
                                       1'b1, STAT_OPENED, '0, MARK_W'(DEPTH)));
      directed_rows.push_back(make_row(MODE_CLOSE, '0, '0, MARK_W'(DEPTH), 1'b0,
                                       1'b1, STAT_CLOSED, '0, '0));

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].result);

      // random part with one overflow run somewhere in the middle
      stop_at = items_sent + RANDOM_ITEMS;
      fill_at = items_sent + $urandom_range(150, 350);
      filled  = 1'b0;
      while (items_sent < stop_at) begin
         if (!filled && items_sent >= fill_at) begin
            fill_stack();
            filled = 1'b1;
         end else begin
            send_random_item();
         end
      end
      if (start) start <= 1'b0;

      while (pending_results.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
